// ===== sv/etd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etd_pkg
// Shared widths, reset values and frame layout of the edge timing decoder.
// ----------------------------------------------------------------------------
package etd_pkg;

  localparam int FRAME_BITS_DEF = 54;

  localparam int TIME_W   = 16;
  localparam int PERIOD_W = 16;
  localparam int NUM_W    = 18;  // 2*diff + period
  localparam int DIV_W    = 17;  // 2*period
  localparam int POS_W    = 17;
  localparam int POS_LO_W = 16;
  localparam int MT_W     = 7;
  localparam int CK_W     = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd33;

  // frame layout, bit j is the j-th received bit
  localparam int START1_BIT = 0;
  localparam int STOP1_BIT  = 17;
  localparam int START2_BIT = 18;
  localparam int POS_LO_BIT = 19;
  localparam int STOP2_BIT  = 35;
  localparam int START3_BIT = 36;
  localparam int POS_HI_BIT = 37;
  localparam int MT_LO_BIT  = 38;
  localparam int CK_LO_BIT  = 45;
  localparam int STOP3_BIT  = 53;

endpackage
`default_nettype wire

// ===== sv/etd_cap_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etd_cap_if
// Edge capture channel: one timestamp per transaction.
// ----------------------------------------------------------------------------
interface etd_cap_if;
  logic                       valid;
  logic                       ready;
  logic [etd_pkg::TIME_W-1:0] capture_time;
  logic                       last_capture;

  modport source (output valid, output capture_time, output last_capture, input ready);
  modport sink   (input valid, input capture_time, input last_capture, output ready);
endinterface
`default_nettype wire

// ===== sv/etd_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etd_res_if
// Decoded frame channel: one frame result per transaction.
// ----------------------------------------------------------------------------
interface etd_res_if;
  logic                      valid;
  logic                      ready;
  logic [etd_pkg::POS_W-1:0] position_raw;
  logic [etd_pkg::MT_W-1:0]  multiturn;
  logic [etd_pkg::CK_W-1:0]  checksum_byte;
  logic                      frame_good;

  modport source (output valid, output position_raw, output multiturn,
                  output checksum_byte, output frame_good, input ready);
  modport sink   (input valid, input position_raw, input multiturn,
                  input checksum_byte, input frame_good, output ready);
endinterface
`default_nettype wire

// ===== sv/etd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [etd_pkg::NUM_W-1:0]   numerator,
  input  wire logic [etd_pkg::DIV_W-1:0]   divisor,
  output      logic [etd_pkg::NUM_W-1:0]   quotient,
  output      logic                        busy
);

  localparam int CNT_W = $clog2(etd_pkg::NUM_W + 1);

  logic [etd_pkg::NUM_W-1:0] acc;
  logic [etd_pkg::DIV_W-1:0] rem;
  logic [etd_pkg::DIV_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;

  logic [etd_pkg::DIV_W:0]   trial;
  logic [etd_pkg::DIV_W:0]   trial_sub;
  logic                      fits;
  logic [etd_pkg::DIV_W-1:0] rem_next;

  always_comb begin
    trial     = {rem, acc[etd_pkg::NUM_W-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = trial >= {1'b0, dvs};
    rem_next  = fits ? trial_sub[etd_pkg::DIV_W-1:0] : trial[etd_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(etd_pkg::NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= numerator;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      acc <= {acc[etd_pkg::NUM_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = acc;

endmodule
`default_nettype wire

// ===== sv/edge_timing_encoder_frame_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edge_timing_encoder_frame_decoder
// Rounds edge intervals of an encoder reply to bit counts, builds the frame
// and decodes position, multiturn, checksum and framing on the last edge.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  cap      | in  | valid / ready   | capture_time[15:0], last_capture
//  res      | out | valid / ready   | position_raw[16:0], multiturn[6:0],
//           |     |                 | checksum_byte[7:0], frame_good
//  cfg      | in  | cfg_we          | cfg_wdata[15:0] = bit_period_ticks
//
//  First two captures of a frame are taken in S_IDLE without a division.
//  Later captures go through the 18-step restoring divider in S_DIV.
//  The last capture, after S_DIV if it went there, passes through S_EMIT to load the result register.
//  A held result stalls only a following last capture; rst is synchronous
//  and needs no clearing pass.
// ----------------------------------------------------------------------------
module edge_timing_encoder_frame_decoder #(
  parameter int FRAME_BITS = etd_pkg::FRAME_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [etd_pkg::PERIOD_W-1:0]   cfg_wdata,
  etd_cap_if.sink                             cap,
  etd_res_if.source                           res
);

  localparam int FILL_W = $clog2(FRAME_BITS + 1);
  localparam int SUM_W  = etd_pkg::NUM_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                         state;
  logic [etd_pkg::PERIOD_W-1:0]   period;
  logic [FRAME_BITS-1:0]          frame;
  logic [FILL_W-1:0]              fill;
  logic [etd_pkg::TIME_W-1:0]     previous_time;
  logic [1:0]                     capture_index;
  logic                           parity_odd;
  logic                           last_q;
  logic                           odd_q;
  logic                           res_valid;

  logic                           accept;
  logic                           div_start;
  logic                           div_busy;
  logic [etd_pkg::NUM_W-1:0]      quotient;
  logic [etd_pkg::PERIOD_W-1:0]   p_eff;
  logic [etd_pkg::TIME_W-1:0]     diff;
  logic [etd_pkg::NUM_W-1:0]      numer;
  logic [etd_pkg::DIV_W-1:0]      divis;
  logic [SUM_W-1:0]               sum;
  logic [FILL_W-1:0]              fill_end;
  logic [FRAME_BITS-1:0]          span;
  logic [FRAME_BITS-1:0]          high;
  logic [FRAME_BITS-1:0]          fv;
  logic                           res_free;

  assign accept    = cap.valid && cap.ready;
  assign cap.ready = (state == S_IDLE);
  assign div_start = accept && (capture_index == 2'd2);
  assign res_free  = !res_valid || res.ready;
  assign res.valid = res_valid;

  always_comb begin
    p_eff = (period == '0) ? etd_pkg::PERIOD_W'(1) : period;
    diff  = cap.capture_time - previous_time;
    numer = {1'b0, diff, 1'b0} + {2'b00, p_eff};
    divis = {p_eff, 1'b0};
    sum   = {1'b0, quotient} + SUM_W'(fill);
    fill_end = (sum > SUM_W'(FRAME_BITS)) ? FILL_W'(FRAME_BITS) : sum[FILL_W-1:0];
    for (int i = 0; i < FRAME_BITS; i++) begin
      span[i] = (FILL_W'(i) >= fill) && (FILL_W'(i) < fill_end);
      high[i] = (FILL_W'(i) >= fill);
    end
    fv = frame | high;
  end

  etd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (numer),
    .divisor   (divis),
    .quotient  (quotient),
    .busy      (div_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      period        <= etd_pkg::PERIOD_RESET;
      frame         <= '0;
      fill          <= '0;
      previous_time <= '0;
      capture_index <= '0;
      parity_odd    <= 1'b0;
      last_q        <= 1'b0;
      odd_q         <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        period <= cfg_wdata;
      end
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            previous_time <= cap.capture_time;
            parity_odd    <= !parity_odd;
            odd_q         <= parity_odd;
            last_q        <= cap.last_capture;
            if (capture_index == 2'd2) begin
              state <= S_DIV;
            end else begin
              capture_index <= capture_index + 2'd1;
              if (cap.last_capture) begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            if (odd_q) begin
              frame <= frame | span;
            end
            fill  <= fill_end;
            state <= last_q ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (res_free) begin
            res_valid     <= 1'b1;
            frame         <= '0;
            fill          <= '0;
            previous_time <= '0;
            capture_index <= '0;
            parity_odd    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && res_free) begin
      res.position_raw  <= {fv[etd_pkg::POS_HI_BIT],
                            fv[etd_pkg::POS_LO_BIT +: etd_pkg::POS_LO_W]};
      res.multiturn     <= fv[etd_pkg::MT_LO_BIT +: etd_pkg::MT_W];
      res.checksum_byte <= fv[etd_pkg::CK_LO_BIT +: etd_pkg::CK_W];
      res.frame_good    <= !fv[etd_pkg::START1_BIT] && !fv[etd_pkg::START2_BIT] &&
                           !fv[etd_pkg::START3_BIT] && fv[etd_pkg::STOP1_BIT] &&
                           fv[etd_pkg::STOP2_BIT] && fv[etd_pkg::STOP3_BIT];
    end
  end

endmodule
`default_nettype wire

// ===== sv/etd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etd_checker
// Port-level checks of the edge timing decoder, bound to the top level.
// ----------------------------------------------------------------------------
module etd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [etd_pkg::POS_W-1:0]  position_raw,
  input wire logic [etd_pkg::MT_W-1:0]   multiturn,
  input wire logic [etd_pkg::CK_W-1:0]   checksum_byte,
  input wire logic                       frame_good
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable({position_raw, multiturn, checksum_byte, frame_good}))
    else $error("result payload changed while stalled");

  // a new result is loaded only while the capture side is held off
  a_emit_blocks_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready) && !$past(in_valid && in_ready))
    else $error("result appeared without a blocked emit cycle");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind edge_timing_encoder_frame_decoder etd_checker u_etd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (cap.valid),
  .in_ready      (cap.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .position_raw  (res.position_raw),
  .multiturn     (res.multiturn),
  .checksum_byte (res.checksum_byte),
  .frame_good    (res.frame_good)
);
`default_nettype wire

// ===== bench/tb_edge_timing_encoder_frame_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edge_timing_encoder_frame_decoder
// Feeds edge timestamps of encoder replies, predicts each decoded frame and
// compares it with the result channel. Random idling on both channels and
// several bit periods are used.
// ----------------------------------------------------------------------------
module tb_edge_timing_encoder_frame_decoder;

  localparam int FRAME_BITS     = etd_pkg::FRAME_BITS_DEF;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 125;
  localparam int PHASE_FRAMES   = 6;
  localparam int FRAMING_BITS[6] = '{etd_pkg::START1_BIT, etd_pkg::STOP1_BIT,
                                     etd_pkg::START2_BIT, etd_pkg::STOP2_BIT,
                                     etd_pkg::START3_BIT, etd_pkg::STOP3_BIT};

  typedef struct {
    logic [etd_pkg::TIME_W-1:0] stamp;
    logic                       fin;
  } capture_t;

  typedef struct {
    logic [etd_pkg::POS_W-1:0] position_raw;
    logic [etd_pkg::MT_W-1:0]  multiturn;
    logic [etd_pkg::CK_W-1:0]  checksum_byte;
    logic                      frame_good;
  } frame_result_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  logic [etd_pkg::PERIOD_W-1:0] cfg_wdata;

  etd_cap_if cap_ch();
  etd_res_if res_ch();

  edge_timing_encoder_frame_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cap       (cap_ch),
    .res       (res_ch)
  );

  always #2 clk = ~clk;

  capture_t      pending_captures[$];
  frame_result_t expected_frames[$];
  capture_t      next_edge;

  int   queued_count   = 0;
  int   queued_frames  = 0;
  int   accepted_count = 0;
  int   failures       = 0;
  int   cap_gap        = 0;
  int   ready_gap      = 0;
  int   quiet_cycles   = 0;
  logic quiet          = 1'b0;

  // decoder image
  logic [etd_pkg::PERIOD_W-1:0] bit_period;
  logic [FRAME_BITS-1:0]        rx_frame;
  int                           rx_fill;
  logic [etd_pkg::TIME_W-1:0]   rx_prev_time;
  int                           rx_edge_count;
  logic                         rx_odd;

  function automatic void clear_frame();
    rx_frame      = '0;
    rx_fill       = 0;
    rx_prev_time  = '0;
    rx_edge_count = 0;
    rx_odd        = 1'b0;
  endfunction

  function automatic void take_edge(input logic [etd_pkg::TIME_W-1:0] t, input logic fin);
    logic [etd_pkg::TIME_W-1:0] gap16;
    int unsigned                eff, nbits, stop;
    logic [FRAME_BITS-1:0]      word;
    frame_result_t              r;
    if (rx_edge_count >= 2) begin
      eff   = (bit_period == '0) ? 1 : int'(bit_period);
      gap16 = t - rx_prev_time;
      nbits = (2 * int'(gap16) + eff) / (2 * eff);
      stop  = rx_fill + nbits;
      if (stop > FRAME_BITS) stop = FRAME_BITS;
      if (rx_odd) begin
        for (int j = rx_fill; j < int'(stop); j++) rx_frame[j] = 1'b1;
      end
      rx_fill = stop;
    end else begin
      rx_edge_count++;
    end
    rx_prev_time = t;
    rx_odd       = ~rx_odd;
    if (fin) begin
      word = rx_frame;
      for (int j = rx_fill; j < FRAME_BITS; j++) word[j] = 1'b1;
      r.position_raw  = {word[etd_pkg::POS_HI_BIT],
                         word[etd_pkg::POS_LO_BIT +: etd_pkg::POS_LO_W]};
      r.multiturn     = word[etd_pkg::MT_LO_BIT +: etd_pkg::MT_W];
      r.checksum_byte = word[etd_pkg::CK_LO_BIT +: etd_pkg::CK_W];
      r.frame_good    = !word[etd_pkg::START1_BIT] && !word[etd_pkg::START2_BIT] &&
                        !word[etd_pkg::START3_BIT] && word[etd_pkg::STOP1_BIT] &&
                        word[etd_pkg::STOP2_BIT] && word[etd_pkg::STOP3_BIT];
      expected_frames.push_back(r);
      clear_frame();
    end
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      failures++;
    end
  endfunction

  function automatic void queue_capture(input logic [etd_pkg::TIME_W-1:0] t, input logic fin);
    capture_t c;
    c.stamp = t;
    c.fin   = fin;
    pending_captures.push_back(c);
    queued_count++;
    if (fin) queued_frames++;
  endfunction

  // turn frame bits into edge times: alternating runs, zeros first
  function automatic void queue_reply(input logic [FRAME_BITS-1:0] bits,
                                      input logic [etd_pkg::PERIOD_W-1:0] p,
                                      input logic jitter);
    int   pe, jm, t, len, j;
    int   runs[$];
    logic v;
    pe = (p == '0) ? 1 : int'(p);
    jm = jitter ? (pe - 1) / 2 : 0;
    t  = $urandom_range(0, 65535);
    queue_capture(t[15:0], 1'b0);
    t += $urandom_range(0, 65535);
    queue_capture(t[15:0], 1'b0);
    j = 0;
    v = 1'b0;
    while (j < FRAME_BITS) begin
      len = 0;
      while (j < FRAME_BITS && bits[j] == v) begin
        len++;
        j++;
      end
      runs.push_back(len);
      v = ~v;
    end
    // a trailing ones run is usually left to the fill
    if (runs.size() % 2 == 0 && $urandom_range(0, 3) != 0) void'(runs.pop_back());
    for (int k = 0; k < runs.size(); k++) begin
      t += runs[k] * pe + int'($urandom_range(0, 2 * jm)) - jm;
      queue_capture(t[15:0], k == runs.size() - 1);
    end
  endfunction

  function automatic void queue_noise(input logic [etd_pkg::PERIOD_W-1:0] p);
    int n, t, pe;
    pe = (p == '0) ? 1 : int'(p);
    n  = $urandom_range(1, 40);
    t  = $urandom_range(0, 65535);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 65535);
      else t += $urandom_range(0, 8 * pe);
      queue_capture(t[15:0], k == n - 1 && $urandom_range(0, 4) != 0);
    end
  endfunction

  task automatic random_traffic(input logic [etd_pkg::PERIOD_W-1:0] p);
    logic [FRAME_BITS-1:0] payload;
    int                    first_item, first_frame;
    first_item  = queued_count;
    first_frame = queued_frames;
    while (queued_count - first_item < PHASE_ITEMS ||
           queued_frames - first_frame < PHASE_FRAMES) begin
      if ($urandom_range(0, 9) < 2) begin
        queue_noise(p);
      end else begin
        payload = FRAME_BITS'({$urandom, $urandom});
        payload[etd_pkg::START1_BIT] = 1'b0;
        payload[etd_pkg::START2_BIT] = 1'b0;
        payload[etd_pkg::START3_BIT] = 1'b0;
        payload[etd_pkg::STOP1_BIT]  = 1'b1;
        payload[etd_pkg::STOP2_BIT]  = 1'b1;
        payload[etd_pkg::STOP3_BIT]  = 1'b1;
        if ($urandom_range(0, 4) == 0)
          payload[FRAMING_BITS[$urandom_range(0, 5)]] ^= 1'b1;
        queue_reply(payload, p, 1'b1);
      end
    end
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || expected_frames.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_bit_period(input logic [etd_pkg::PERIOD_W-1:0] v);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    bit_period = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // capture driver
  always @(posedge clk) begin
    if (rst) begin
      cap_ch.valid <= 1'b0;
      cap_gap = 0;
    end else begin
      if (cap_ch.valid && cap_ch.ready) begin
        take_edge(cap_ch.capture_time, cap_ch.last_capture);
        accepted_count++;
      end
      if (!cap_ch.valid || cap_ch.ready) begin
        if (cap_gap > 0) begin
          cap_gap--;
          cap_ch.valid <= 1'b0;
        end else if (pending_captures.size() != 0 && !quiet &&
                     $urandom_range(0, 7) == 0) begin
          cap_gap = $urandom_range(0, 18);
          cap_ch.valid <= 1'b0;
        end else if (pending_captures.size() != 0) begin
          next_edge = pending_captures.pop_front();
          cap_ch.valid        <= 1'b1;
          cap_ch.capture_time <= next_edge.stamp;
          cap_ch.last_capture <= next_edge.fin;
        end else begin
          cap_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      ready_gap = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_frames.size() == 0) begin
          $error("frame result with no transaction pending");
          failures++;
        end else begin
          check_field("position_raw", expected_frames[0].position_raw, res_ch.position_raw);
          check_field("multiturn", expected_frames[0].multiturn, res_ch.multiturn);
          check_field("checksum_byte", expected_frames[0].checksum_byte,
                      res_ch.checksum_byte);
          check_field("frame_good", expected_frames[0].frame_good, res_ch.frame_good);
          void'(expected_frames.pop_front());
        end
      end
      if (ready_gap > 0) begin
        ready_gap--;
        res_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        ready_gap = $urandom_range(0, 18);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (cap_ch.valid && cap_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [FRAME_BITS-1:0]        fixed_frame;
    logic [etd_pkg::PERIOD_W-1:0] phase_periods[6];
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    cap_ch.valid        = 1'b0;
    cap_ch.capture_time = '0;
    cap_ch.last_capture = 1'b0;
    res_ch.ready        = 1'b0;
    bit_period          = etd_pkg::PERIOD_RESET;
    clear_frame();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // early last on the first and on the second capture
    queue_capture(16'h0000, 1'b1);
    queue_capture(16'hFFFF, 1'b0);
    queue_capture(16'h0000, 1'b1);
    // zero interval, an interval that overflows the frame, then a wrapped one
    queue_capture(16'hFFFF, 1'b0);
    queue_capture(16'h0000, 1'b0);
    queue_capture(16'h0000, 1'b0);
    queue_capture(16'hFFFF, 1'b0);
    queue_capture(16'h0000, 1'b1);
    // clean frame at the reset period
    fixed_frame = '0;
    fixed_frame[etd_pkg::STOP1_BIT] = 1'b1;
    fixed_frame[etd_pkg::STOP2_BIT] = 1'b1;
    fixed_frame[etd_pkg::STOP3_BIT] = 1'b1;
    fixed_frame[etd_pkg::POS_LO_BIT +: etd_pkg::POS_LO_W] = '1;
    fixed_frame[etd_pkg::POS_HI_BIT] = 1'b1;
    fixed_frame[etd_pkg::CK_LO_BIT +: etd_pkg::CK_W] = '1;
    queue_reply(fixed_frame, bit_period, 1'b0);
    wait_idle();

    phase_periods = '{16'd0, 16'd1, 16'hFFFF, 16'd7, 16'd0, etd_pkg::PERIOD_RESET};
    phase_periods[4] = etd_pkg::PERIOD_W'($urandom_range(2, 400));
    for (int k = 0; k < 6; k++) begin
      if (k == 5) quiet = 1'b1;
      load_bit_period(phase_periods[k]);
      random_traffic(phase_periods[k]);
      wait_idle();
    end

    if (failures == 0 && expected_frames.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
